// ===== hw/rtl/lrm_pkg.sv =====
// Shared types and codes for the list reconcile match block.
// No dependencies; imported by every module of the block.
package lrm_pkg;

  localparam int KEY_CHARS = 6;
  localparam int KEY_W     = 8 * KEY_CHARS;
  localparam int ID_W      = 32;
  localparam int IDX_W     = 8;
  localparam int KLEN_W    = 3;

  localparam logic [KLEN_W-1:0] KEY_LEN_RESET = 3'd6;

  // input op codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_FOUND = 2'd1;
  localparam logic [1:0] KIND_DEL   = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  typedef struct packed {
    logic [1:0]             op;
    logic [KEY_W-1:0]       key;
    logic signed [ID_W-1:0] entry_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [IDX_W-1:0]       index;
    logic signed [ID_W-1:0] deleted_id;
    logic                   overflow;
    logic                   last;
  } out_item_t;

endpackage

// ===== hw/rtl/lrm_key_cmp.sv =====
// Prefix key compare with strncmp rules: stops at the first zero byte.
// Depends on lrm_pkg for key geometry.
module lrm_key_cmp
  import lrm_pkg::*;
(
  input  logic [KEY_W-1:0]  stored_key,
  input  logic [KEY_W-1:0]  query_key,
  input  logic [KLEN_W-1:0] key_len,
  output logic              hit
);

  always_comb begin
    logic       live;
    logic [7:0] ca;
    logic [7:0] cb;
    live = 1'b1;
    hit  = 1'b1;
    ca   = '0;
    cb   = '0;
    for (int i = 0; i < KEY_CHARS; i++) begin
      ca = stored_key[KEY_W-1-8*i -: 8];
      cb = query_key[KEY_W-1-8*i -: 8];
      if (live && (KLEN_W'(i) < key_len)) begin
        if (ca != cb) begin
          hit  = 1'b0;
          live = 1'b0;
        end else if (ca == 8'd0) begin
          live = 1'b0;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/list_reconcile_match_top.sv =====
// Top level of the list reconcile match block: base table memory, scan
// sequencer and output register. Depends on lrm_pkg and lrm_key_cmp.
//
//   channel | signals                        | direction | payload
//   --------+--------------------------------+-----------+------------------------
//   in      | in_valid, in_stall, in_data    | to block  | op, key, entry_id
//   out     | out_valid, out_stall, out_data | from blk  | kind, index, deleted_id,
//           |                                |           | overflow, last
//   cfg     | cfg_we, cfg_wdata              | to block  | key_len
//
// One item at a time. A query reads the stored keys in order through the
// single read port of the base memory, one stored key per cycle while the
// output is free, and the compare runs in the cycle after the read. An end
// item steps through the table, skips matched entries, reads each unmatched
// entry and emits a deletion for it, then at the end of the table emits the
// done result. Output stalls hold the scan and the end pass.
// Reset (rst, synchronous) clears counters, flags and the matched bits; the
// key/id memory needs no clearing since only entries below base_count are read.
// in_stall is high whenever an item is in progress.
module list_reconcile_match_top
  import lrm_pkg::*;
#(
  parameter int BASE_DEPTH = 32
)(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [KLEN_W-1:0] cfg_wdata
);

  localparam int CNT_W  = $clog2(BASE_DEPTH + 1);
  localparam int ADDR_W = (BASE_DEPTH > 1) ? $clog2(BASE_DEPTH) : 1;
  localparam int MEM_W  = KEY_W + ID_W;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(BASE_DEPTH);

  // sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN     = 3'd1;
  localparam logic [2:0] ST_DEL      = 3'd2;
  localparam logic [2:0] ST_DEL_WAIT = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  logic [2:0]            state;
  logic [KLEN_W-1:0]     key_len;
  logic [CNT_W-1:0]      base_count;
  logic [IDX_W-1:0]      query_count;
  logic                  overflow_seen;
  logic [BASE_DEPTH-1:0] matched;

  // per-item working registers
  logic [KEY_W-1:0]      q_key;
  logic [IDX_W-1:0]      q_idx;
  logic [CNT_W-1:0]      scan_idx;  // next address to read
  logic [CNT_W-1:0]      cmp_idx;   // address whose data sits in rd_data
  logic                  cmp_vld;
  logic [CNT_W-1:0]      del_idx;

  // base table: key in the upper bits, id below
  logic [MEM_W-1:0]      mem [BASE_DEPTH];
  logic [MEM_W-1:0]      rd_data;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;

  logic                  in_acc;
  logic                  out_free;
  logic                  out_set;
  logic                  hit;
  logic                  load_ok;

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign load_ok  = in_acc && (in_data.op == OP_LOAD) && (base_count != FULL);

  // a new result item enters the output register this cycle
  always_comb begin
    unique case (state)
      ST_SCAN:              out_set = out_free && ((cmp_vld && hit) ||
                                                   (scan_idx == base_count));
      ST_DEL_WAIT, ST_DONE: out_set = out_free;
      default:              out_set = 1'b0;
    endcase
  end

  lrm_key_cmp u_cmp (
    .stored_key (rd_data[MEM_W-1 -: KEY_W]),
    .query_key  (q_key),
    .key_len    (key_len),
    .hit        (hit)
  );

  // read port: the scan reads in order, the end pass reads unmatched entries
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_idx[ADDR_W-1:0];
    unique case (state)
      ST_SCAN: begin
        rd_en   = out_free && !(cmp_vld && hit) && (scan_idx != base_count);
        rd_addr = scan_idx[ADDR_W-1:0];
      end
      ST_DEL: begin
        rd_en   = (del_idx != base_count) && !matched[del_idx[ADDR_W-1:0]];
        rd_addr = del_idx[ADDR_W-1:0];
      end
      default: begin
        rd_en   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      mem[base_count[ADDR_W-1:0]] <= {in_data.key, in_data.entry_id};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_len <= KEY_LEN_RESET;
    end else if (cfg_we) begin
      key_len <= cfg_wdata;
    end
  end

  // payload-only registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_key <= in_data.key;
      q_idx <= query_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      base_count    <= '0;
      query_count   <= '0;
      overflow_seen <= 1'b0;
      matched       <= '0;
      scan_idx      <= '0;
      cmp_idx       <= '0;
      cmp_vld       <= 1'b0;
      del_idx       <= '0;
      out_valid     <= 1'b0;
      out_data      <= '0;
    end else begin
      if (out_valid && !out_stall && !out_set) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_data.op)
              OP_LOAD: begin
                if (base_count != FULL) begin
                  matched[base_count[ADDR_W-1:0]] <= 1'b0;
                  base_count <= base_count + 1'b1;
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              OP_QUERY: begin
                scan_idx <= '0;
                cmp_vld  <= 1'b0;
                state    <= ST_SCAN;
                if (query_count != '1) begin
                  query_count <= query_count + 1'b1;
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              OP_END: begin
                del_idx <= '0;
                state   <= ST_DEL;
              end
              default: begin
                // unused op: dropped
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (out_free) begin
            priority if (cmp_vld && hit) begin
              matched[cmp_idx[ADDR_W-1:0]] <= 1'b1;
              out_valid <= 1'b1;
              out_data  <= '{kind: KIND_FOUND, index: IDX_W'(cmp_idx),
                             deleted_id: '0, overflow: 1'b0, last: 1'b0};
              state     <= ST_IDLE;
            end else if (scan_idx != base_count) begin
              cmp_idx  <= scan_idx;
              cmp_vld  <= 1'b1;
              scan_idx <= scan_idx + 1'b1;
            end else begin
              out_valid <= 1'b1;
              out_data  <= '{kind: KIND_ADD, index: q_idx,
                             deleted_id: '0, overflow: 1'b0, last: 1'b0};
              state     <= ST_IDLE;
            end
          end
        end
        ST_DEL: begin
          priority if (del_idx == base_count) begin
            state <= ST_DONE;
          end else if (matched[del_idx[ADDR_W-1:0]]) begin
            del_idx <= del_idx + 1'b1;
          end else begin
            state <= ST_DEL_WAIT;
          end
        end
        ST_DEL_WAIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= '{kind: KIND_DEL, index: IDX_W'(del_idx),
                           deleted_id: rd_data[ID_W-1:0],
                           overflow: 1'b0, last: 1'b0};
            del_idx   <= del_idx + 1'b1;
            state     <= ST_DEL;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            out_data      <= '{kind: KIND_DONE, index: '0, deleted_id: '0,
                               overflow: overflow_seen, last: 1'b1};
            matched       <= '0;
            base_count    <= '0;
            query_count   <= '0;
            overflow_seen <= 1'b0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // table never grows past its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    base_count <= FULL)
    else $error("base_count beyond table depth");

  // only the done result carries last
  a_last_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last |-> out_data.kind == KIND_DONE)
    else $error("last set on a result other than done");

  // a deletion is only emitted for an entry that was never matched
  a_del_unmatched: assert property (@(posedge clk) disable iff (rst)
    state == ST_DEL_WAIT |-> !matched[del_idx[ADDR_W-1:0]] && del_idx < base_count)
    else $error("deletion of a matched or absent entry");

  // done clears the table on the following cycle
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_free |=> base_count == '0 && matched == '0
      && state == ST_IDLE)
    else $error("table not cleared after done");

  // the compare only looks at entries that are in the table
  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && cmp_vld |-> cmp_idx < base_count)
    else $error("compare on an entry outside the table");

endmodule

// ===== sim/lrm_match_checker.sv =====
// Scoreboard for list_reconcile_match_top: keeps its own base table, predicts
// the result items of every accepted input item and checks them in order.
// Depends on lrm_pkg.
module lrm_match_checker
  import lrm_pkg::*;
#(
  parameter int BASE_DEPTH = 32
)(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [KLEN_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [KEY_W-1:0]       base_key [BASE_DEPTH];
  logic signed [ID_W-1:0] base_id  [BASE_DEPTH];
  logic                   hit      [BASE_DEPTH];
  int                     base_cnt;
  int                     query_cnt;
  logic                   ovf_seen;
  logic [KLEN_W-1:0]      key_len;
  out_item_t              result_q [$];

  // equal on the first n characters, a zero byte ends the string
  function automatic bit prefix_equal(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b, int n);
    logic [7:0] ca, cb;
    for (int i = 0; i < n && i < KEY_CHARS; i++) begin
      ca = a[KEY_W-8-8*i +: 8];
      cb = b[KEY_W-8-8*i +: 8];
      if (ca != cb) return 1'b0;
      if (ca == 8'h00) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic out_item_t make_result(logic [1:0] kind, int idx,
                                            logic signed [ID_W-1:0] id,
                                            logic ovf, logic fin);
    out_item_t r;
    r.kind       = kind;
    r.index      = IDX_W'(idx);
    r.deleted_id = id;
    r.overflow   = ovf;
    r.last       = fin;
    return r;
  endfunction

  task automatic reconcile(input in_item_t item);
    int i;
    case (item.op)
      OP_LOAD: begin
        if (base_cnt < BASE_DEPTH) begin
          base_key[base_cnt] = item.key;
          base_id[base_cnt]  = item.entry_id;
          hit[base_cnt]      = 1'b0;
          base_cnt++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      OP_QUERY: begin
        i = 0;
        while (i < base_cnt && !prefix_equal(base_key[i], item.key, key_len)) i++;
        if (i < base_cnt) begin
          hit[i] = 1'b1;
          result_q.push_back(make_result(KIND_FOUND, i, '0, 1'b0, 1'b0));
        end else begin
          result_q.push_back(make_result(KIND_ADD, query_cnt, '0, 1'b0, 1'b0));
        end
        if (query_cnt < 255) query_cnt++;
        else ovf_seen = 1'b1;
      end
      OP_END: begin
        for (i = 0; i < base_cnt; i++) begin
          if (!hit[i]) result_q.push_back(make_result(KIND_DEL, i, base_id[i], 1'b0, 1'b0));
        end
        result_q.push_back(make_result(KIND_DONE, 0, '0, ovf_seen, 1'b1));
        for (i = 0; i < BASE_DEPTH; i++) hit[i] = 1'b0;
        base_cnt  = 0;
        query_cnt = 0;
        ovf_seen  = 1'b0;
      end
      default: ;  // unused op, no effect
    endcase
  endtask

  task automatic compare_result(input out_item_t want, input out_item_t got);
    bit bad;
    bad = 1'b0;
    if (got.kind !== want.kind) begin
      $display("%0t: kind mismatch: expected %0d, got %0d", $time, want.kind, got.kind);
      bad = 1'b1;
    end
    if (got.index !== want.index) begin
      $display("%0t: index mismatch: expected %0d, got %0d", $time, want.index, got.index);
      bad = 1'b1;
    end
    if (got.deleted_id !== want.deleted_id) begin
      $display("%0t: deleted_id mismatch: expected %0d, got %0d", $time,
               want.deleted_id, got.deleted_id);
      bad = 1'b1;
    end
    if (got.overflow !== want.overflow) begin
      $display("%0t: overflow mismatch: expected %0b, got %0b", $time,
               want.overflow, got.overflow);
      bad = 1'b1;
    end
    if (got.last !== want.last) begin
      $display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, got.last);
      bad = 1'b1;
    end
    if (bad) fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BASE_DEPTH; i++) hit[i] = 1'b0;
      base_cnt   = 0;
      query_cnt  = 0;
      ovf_seen   = 1'b0;
      key_len    = KEY_LEN_RESET;
      fail_count = 0;
      result_q.delete();
    end else begin
      if (cfg_we) key_len = cfg_wdata;
      if (in_valid && !in_stall) reconcile(in_data);
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result item: expected none, got %p", $time, out_data);
          fail_count++;
        end else begin
          compare_result(result_q.pop_front(), out_data);
        end
      end
    end
    pending <= result_q.size();
  end

endmodule

// ===== sim/tb_list_reconcile_match_top.sv =====
// Testbench top for list_reconcile_match_top: drives load, query and end
// items plus key_len writes, and gives the verdict. Depends on lrm_pkg,
// lrm_match_checker and the block itself.
module tb_list_reconcile_match_top
  import lrm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BASE_DEPTH   = 32;
  localparam int DRAIN_CYCLES = 2 * BASE_DEPTH + 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 250;
  // op value the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum int {FLOW_FREE, FLOW_HALF, FLOW_LIGHT, FLOW_HEAVY} flow_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [KLEN_W-1:0] cfg_wdata = KEY_LEN_RESET;
  int                fail_count;
  int                pending;

  // sender pacing and stimulus bookkeeping
  int                burst_left = 4;
  bit                no_gaps    = 1'b0;
  bit                driving    = 1'b0;   // in_valid currently held high
  int                fed        = 0;      // counted random items
  int                cycles     = 0;
  logic [KEY_W-1:0]  pool [$];            // base keys of the current list

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  list_reconcile_match_top #(.BASE_DEPTH(BASE_DEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lrm_match_checker #(.BASE_DEPTH(BASE_DEPTH)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // watchdog: a hung handshake or a missing result ends up here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: switches between stall patterns at random, from never stalling
  // to stalling almost all the time.
  flow_t flow_mode = FLOW_FREE;
  int    flow_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (flow_left == 0) begin
        flow_mode = flow_t'($urandom_range(0, 3));
        flow_left = $urandom_range(20, 200);
      end
      flow_left--;
      case (flow_mode)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
        FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        default:    out_stall <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // Present one item and hold it until the block takes it. Bursts of random
  // length, then a random gap with valid low, unless gaps are off.
  task automatic offer_item(input logic [1:0] op, input logic [KEY_W-1:0] key,
                            input logic signed [ID_W-1:0] id);
    in_item_t item;
    item.op       = op;
    item.key      = key;
    item.entry_id = id;
    in_valid <= 1'b1;
    in_data  <= item;
    driving   = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!no_gaps) begin
        in_valid <= 1'b0;
        driving   = 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // Stop sending, wait for every expected result, then let a trailing load
  // or end item finish inside the block.
  task automatic settle;
    if (driving) begin
      in_valid <= 1'b0;
      driving   = 1'b0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // only called with the block idle (after settle)
  task automatic write_key_len(input logic [KLEN_W-1:0] len);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Keys mostly from a three letter alphabet so prefixes collide, with some
  // zero bytes (early string end) and some arbitrary bytes.
  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    for (int i = 0; i < KEY_CHARS; i++) begin
      case ($urandom_range(0, 7))
        0:       k[8*i +: 8] = 8'h00;
        1, 2:    k[8*i +: 8] = 8'($urandom_range(1, 255));
        default: k[8*i +: 8] = 8'(8'h61 + $urandom_range(0, 2));
      endcase
    end
    return k;
  endfunction

  // Query keys: mostly copies of stored keys, some changed in one character
  // or cut short by a zero byte, the rest fresh.
  function automatic logic [KEY_W-1:0] query_key();
    logic [KEY_W-1:0] k;
    int               p;
    if (pool.size() == 0 || $urandom_range(0, 4) == 0) return rand_key();
    k = pool[$urandom_range(0, pool.size() - 1)];
    p = $urandom_range(0, KEY_CHARS - 1);
    case ($urandom_range(0, 3))
      0:       k[KEY_W-8-8*p +: 8] = 8'($urandom_range(0, 255));
      1:       k[KEY_W-8-8*p +: 8] = 8'h00;
      default: ;
    endcase
    return k;
  endfunction

  // One list: loads mostly ahead of queries, with a few mixed in, the odd
  // ignored op and sender pause, closed by an end item.
  task automatic run_list(input int loads, input int queries);
    logic [KEY_W-1:0] k;
    pool.delete();
    while (loads + queries > 0) begin
      if ($urandom_range(0, 29) == 0)
        offer_item(OP_UNUSED, rand_key(), $urandom());
      if ($urandom_range(0, 39) == 0) settle;
      if (loads > 0 && (queries == 0 || $urandom_range(0, 9) != 0)) begin
        // duplicate base keys now and then
        if (pool.size() != 0 && $urandom_range(0, 4) == 0)
          k = pool[$urandom_range(0, pool.size() - 1)];
        else
          k = rand_key();
        pool.push_back(k);
        offer_item(OP_LOAD, k, $urandom());
        loads--;
      end else begin
        offer_item(OP_QUERY, query_key(), $urandom());
        queries--;
      end
      fed++;
    end
    offer_item(OP_END, rand_key(), $urandom());
    fed++;
  endtask

  initial begin
    int phase;
    int nl, nq;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed, key_len at its reset value of 6 ---
    offer_item(OP_QUERY, "abcdef", 0);                         // empty table: add
    offer_item(OP_LOAD, 48'hFFFF_FFFF_FFFF, 32'sh7FFF_FFFF);   // field extremes
    offer_item(OP_LOAD, 48'h0, 32'sh8000_0000);
    offer_item(OP_LOAD, {"ab", 8'h00, "xyz"}, -1);
    offer_item(OP_LOAD, 48'hFFFF_FFFF_FFFF, 0);                // duplicate key
    offer_item(OP_LOAD, "abcdef", 5);
    offer_item(OP_QUERY, 48'hFFFF_FFFF_FFFF, 0);               // first of duplicates
    offer_item(OP_QUERY, 48'h0, 0);                            // empty string
    offer_item(OP_QUERY, {"ab", 8'h00, "qqq"}, 0);             // match ends at zero
    offer_item(OP_QUERY, "abcdeg", 0);                         // last char differs
    offer_item(OP_UNUSED, "zzzzzz", 7);                        // ignored
    offer_item(OP_END, 48'h0, 0);                              // duplicate deleted

    // zero key_len: every query hits the first entry
    settle;
    write_key_len(3'd0);
    offer_item(OP_LOAD, "abcabc", 11);
    offer_item(OP_LOAD, "xyzxyz", 12);
    offer_item(OP_QUERY, "qqqqqq", 0);
    offer_item(OP_END, 48'h0, 0);

    // key_len past the key width compares all six characters
    settle;
    write_key_len(3'd7);
    offer_item(OP_LOAD, "abcdef", 21);
    offer_item(OP_QUERY, "abcdef", 0);
    offer_item(OP_QUERY, "abcdeg", 0);
    offer_item(OP_END, 48'h0, 0);

    // --- random lists; the first eight walk through every key_len ---
    phase = 0;
    while (fed < RANDOM_ITEMS) begin
      settle;
      write_key_len((phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7)));
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        nl = $urandom_range(30, 36);   // may fill the table and spill loads
        nq = $urandom_range(5, 15);
      end else begin
        nl = $urandom_range(0, 10);
        nq = $urandom_range(0, 14);
      end
      run_list(nl, nq);
      phase++;
    end

    settle;
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lrm_pkg.sv
hw/rtl/lrm_key_cmp.sv
hw/rtl/list_reconcile_match_top.sv
sim/lrm_match_checker.sv
sim/tb_list_reconcile_match_top.sv
